// File: rtl/vfo_pkg.sv
`timescale 1ns / 1ps

package vfo_pkg;

   localparam int FreqWidth   = 27;
   localparam int BcdWidth    = 32;
   localparam int SynthWidth  = 36;
   localparam int SumWidth    = 36;
   localparam int NumDigits   = 8;
   localparam int CntWidth    = $clog2(FreqWidth);

   localparam logic [FreqWidth-1:0] FreqLimit  = 27'd99999999;
   localparam logic [FreqWidth-1:0] MinReset   = 27'd1000000;
   localparam logic [FreqWidth-1:0] MaxReset   = 27'd30000000;
   localparam logic [FreqWidth-1:0] HomeReset  = 27'd14150000;
   localparam logic [8:0]           SynthScale = 9'd400;

   localparam logic [1:0] CSR_MIN  = 2'd0;
   localparam logic [1:0] CSR_MAX  = 2'd1;
   localparam logic [1:0] CSR_HOME = 2'd2;

   localparam logic OP_TUNE = 1'b0;
   localparam logic OP_HOME = 1'b1;

   localparam logic [1:0] MODE_OTHER = 2'd0;
   localparam logic [1:0] MODE_USB   = 2'd1;
   localparam logic [1:0] MODE_LSB   = 2'd2;
   localparam logic [1:0] MODE_CW    = 2'd3;

   localparam logic signed [FreqWidth:0] OffsetUsb = -28'sd1500;
   localparam logic signed [FreqWidth:0] OffsetLsb = 28'sd1500;
   localparam logic signed [FreqWidth:0] OffsetCw  = -28'sd700;

   typedef struct packed {
      logic              operation;
      logic signed [7:0] rotations;
      logic [2:0]        cursor_position;
      logic [1:0]        sideband_mode;
   } req_type;

   typedef struct packed {
      logic [FreqWidth-1:0]  tuned_frequency;
      logic [BcdWidth-1:0]   bcd_digits;
      logic [SynthWidth-1:0] synth_word;
      logic                  was_clamped;
   } rsp_type;

   typedef struct packed {
      logic load_item;
      logic mul;
      logic add;
      logic ofs;
      logic conv;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic conv_done;
   } dp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_OFS,
      ST_CONV,
      ST_DONE
   } state_type;

   function automatic logic [FreqWidth-1:0] pow_ten(input logic [3:0] radix);
      logic [FreqWidth-1:0] p;
      case (radix)
         4'd0: p = 27'd1;
         4'd1: p = 27'd10;
         4'd2: p = 27'd100;
         4'd3: p = 27'd1000;
         4'd4: p = 27'd10000;
         4'd5: p = 27'd100000;
         4'd6: p = 27'd1000000;
         4'd7: p = 27'd10000000;
         default: p = 27'd100000000;
      endcase
      return p;
   endfunction

   function automatic logic [FreqWidth-1:0] sat_freq(input logic [FreqWidth-1:0] v);
      return (v > FreqLimit) ? FreqLimit : v;
   endfunction

endpackage

// File: rtl/vfo_dp.sv
`timescale 1ns / 1ps

module vfo_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  vfo_pkg::req_type        req_data,
   input  logic                    csr_wen,
   input  logic [1:0]              csr_index,
   input  logic [26:0]             csr_wdata,
   input  vfo_pkg::dp_cmd_type     cmd,
   output vfo_pkg::dp_status_type  status,
   output vfo_pkg::rsp_type        rsp_data
);
   import vfo_pkg::*;

   logic [FreqWidth-1:0]        min_ff, max_ff, home_ff, cur_ff;
   logic [FreqWidth-1:0]        min_in, max_in, home_in, cur_in;
   req_type                     item_ff;
   logic signed [SumWidth-1:0]  prod_ff, prod_in;
   logic                        clamp_ff, clamp_in;
   logic [FreqWidth-1:0]        lo_ff, lo_in;
   logic [FreqWidth-1:0]        bin_ff, bin_in;
   logic [BcdWidth-1:0]         bcd_ff, bcd_in;
   logic [SynthWidth-1:0]       synth_ff, synth_in;
   logic [CntWidth-1:0]         cnt_ff, cnt_in;
   rsp_type                     out_ff;

   logic [2:0]                  cur_sel;
   logic [3:0]                  radix;
   logic signed [FreqWidth:0]   pow_s;
   logic signed [SumWidth-1:0]  sum, hi_s, lo_s;
   logic signed [FreqWidth:0]   offset, lo_sum;
   logic [FreqWidth-1:0]        wr_val;
   logic [BcdWidth-1:0]         bcd_adj;

   always_comb begin
      wr_val = sat_freq(csr_wdata);
      min_in = min_ff;
      max_in = max_ff;
      home_in = home_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_MIN:  min_in = wr_val;
            CSR_MAX:  max_in = wr_val;
            CSR_HOME: home_in = wr_val;
            default:  ;
         endcase
      end
   end

   always_comb begin
      cur_sel = ({1'b0, item_ff.cursor_position} >= 4'(NumDigits)) ?
                3'(NumDigits - 1) : item_ff.cursor_position;
      radix   = 4'(NumDigits - 1) - {1'b0, cur_sel};
      pow_s   = signed'({1'b0, pow_ten(radix)});
      prod_in = prod_ff;
      if (cmd.mul) begin
         prod_in = item_ff.rotations * pow_s;
      end
   end

   always_comb begin
      sum  = signed'({{(SumWidth-FreqWidth){1'b0}}, cur_ff}) + prod_ff;
      hi_s = signed'({{(SumWidth-FreqWidth){1'b0}}, max_ff});
      lo_s = signed'({{(SumWidth-FreqWidth){1'b0}}, min_ff});
      cur_in   = cur_ff;
      clamp_in = clamp_ff;
      if (cmd.add) begin
         clamp_in = 1'b0;
         if (item_ff.operation == OP_HOME) begin
            cur_in = home_ff;
         end else if (sum > hi_s) begin
            cur_in   = max_ff;
            clamp_in = 1'b1;
         end else if (sum < lo_s) begin
            cur_in   = min_ff;
            clamp_in = 1'b1;
         end else begin
            cur_in = sum[FreqWidth-1:0];
         end
      end
   end

   always_comb begin
      case (item_ff.sideband_mode)
         MODE_USB: offset = OffsetUsb;
         MODE_LSB: offset = OffsetLsb;
         MODE_CW:  offset = OffsetCw;
         default:  offset = '0;
      endcase
      lo_sum = signed'({1'b0, cur_ff}) + offset;
      lo_in  = lo_ff;
      if (cmd.ofs) begin
         lo_in = lo_sum[FreqWidth] ? '0 : lo_sum[FreqWidth-1:0];
      end
   end

   always_comb begin
      for (int d = 0; d < BcdWidth / 4; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ?
                             bcd_ff[4*d +: 4] + 4'd3 : bcd_ff[4*d +: 4];
      end
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      synth_in = synth_ff;
      if (cmd.ofs) begin
         bin_in = cur_ff;
         bcd_in = '0;
         cnt_in = CntWidth'(FreqWidth - 1);
      end else if (cmd.conv) begin
         bin_in   = {bin_ff[FreqWidth-2:0], 1'b0};
         bcd_in   = {bcd_adj[BcdWidth-2:0], bin_ff[FreqWidth-1]};
         cnt_in   = cnt_ff - CntWidth'(1);
         synth_in = {{(SynthWidth-FreqWidth){1'b0}}, lo_ff} *
                    {{(SynthWidth-9){1'b0}}, SynthScale};
      end
   end

   assign status.conv_done = (cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= MinReset;
         max_ff  <= MaxReset;
         home_ff <= HomeReset;
         cur_ff  <= HomeReset;
      end else begin
         min_ff  <= min_in;
         max_ff  <= max_in;
         home_ff <= home_in;
         cur_ff  <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
      prod_ff  <= prod_in;
      clamp_ff <= clamp_in;
      lo_ff    <= lo_in;
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      cnt_ff   <= cnt_in;
      synth_ff <= synth_in;
      if (cmd.load_out) begin
         out_ff.tuned_frequency <= cur_ff;
         out_ff.bcd_digits      <= bcd_ff;
         out_ff.synth_word      <= synth_ff;
         out_ff.was_clamped     <= clamp_ff;
      end
   end

   assign rsp_data = out_ff;

endmodule

// File: rtl/vfo_ctrl.sv
`timescale 1ns / 1ps

module vfo_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output vfo_pkg::dp_cmd_type     cmd,
   input  vfo_pkg::dp_status_type  status
);
   import vfo_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_OFS;
         end
         ST_OFS: begin
            cmd.ofs  = 1'b1;
            state_in = ST_CONV;
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            if (status.conv_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while an item is in flight");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten before transaction");

   a_conv_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && status.conv_done) |=> (state_ff == ST_DONE))
      else $error("conversion did not finish");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_out))
      else $error("result valid without load");
`endif

endmodule

// File: rtl/vfo_tuning_accumulator.sv
`timescale 1ns / 1ps

// Receiver tuning register. Each request transaction tunes or homes the
// frequency and returns one response: frequency, packed BCD digits,
// synthesizer word and clamp flag. A request is taken only when the block
// is idle; the next request can be taken in the cycle after the response
// is loaded. The BCD digits come from a 27-step shift-and-add-3
// conversion. A finished response waits in its output register without
// blocking the next request; if the previous response is still waiting
// when the next item finishes, hold that item until the earlier
// transaction completes. CSR writes apply in the cycle they are seen.
module vfo_tuning_accumulator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vfo_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vfo_pkg::rsp_type  rsp_data,
   input  logic              csr_wen,
   input  logic [1:0]        csr_index,
   input  logic [26:0]       csr_wdata
);
   import vfo_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   vfo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   vfo_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

// File: bench/vfo_tuning_accumulator_tb.sv
`timescale 1ns / 1ps

module vfo_tuning_accumulator_tb;
   import vfo_pkg::*;

   typedef struct packed {
      bit          is_write;
      logic [1:0]  reg_index;
      logic [26:0] reg_value;
      req_type     item;
      bit          typed;
      rsp_type     result;
   } script_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_wen;
   logic [1:0]  csr_index;
   logic [26:0] csr_wdata;

   logic [26:0]    freq_min_reg;
   logic [26:0]    freq_max_reg;
   logic [26:0]    freq_home_reg;
   logic [26:0]    tracked_frequency;
   rsp_type        expected_tunings[$];
   script_row_type script[$];
   bit             row_typed;
   rsp_type        row_result;
   int             mismatch_count;
   int             burst_left;

   vfo_tuning_accumulator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [26:0] limit_frequency(input logic [26:0] v);
      return (v > 27'd99999999) ? 27'd99999999 : v;
   endfunction

   function automatic rsp_type next_tuning(input req_type r);
      rsp_type o;
      longint  hi;
      longint  lo;
      longint  sum;
      longint  step;
      longint  offset;
      longint  shifted;
      longint  f;
      int      k;
      o = '0;
      hi = longint'(limit_frequency(freq_max_reg));
      lo = longint'(limit_frequency(freq_min_reg));
      if (r.operation == OP_HOME) begin
         tracked_frequency = limit_frequency(freq_home_reg);
      end else begin
         step = 1;
         for (k = int'(r.cursor_position); k < NumDigits - 1; k++) step = step * 10;
         sum = longint'(tracked_frequency);
         sum = sum + longint'($signed(r.rotations)) * step;
         if (sum > hi) begin
            tracked_frequency = hi[26:0];
            o.was_clamped = 1'b1;
         end else if (sum < lo) begin
            tracked_frequency = lo[26:0];
            o.was_clamped = 1'b1;
         end else begin
            tracked_frequency = sum[26:0];
         end
      end
      case (r.sideband_mode)
         MODE_USB: offset = -1500;
         MODE_LSB: offset = 1500;
         MODE_CW:  offset = -700;
         default:  offset = 0;
      endcase
      shifted = longint'(tracked_frequency);
      shifted = shifted + offset;
      if (shifted < 0) shifted = 0;
      o.synth_word = 36'(shifted * 400);
      o.tuned_frequency = tracked_frequency;
      f = longint'(tracked_frequency);
      for (k = 0; k < 8; k++) begin
         o.bcd_digits[4*k +: 4] = 4'(f % 10);
         f = f / 10;
      end
      return o;
   endfunction

   function automatic req_type make_req(input logic op, input logic [7:0] rot,
                                        input logic [2:0] cursor, input logic [1:0] mode);
      req_type r;
      r.operation = op;
      r.rotations = rot;
      r.cursor_position = cursor;
      r.sideband_mode = mode;
      return r;
   endfunction

   function automatic logic [26:0] pick_frequency();
      logic [26:0] v;
      case ($urandom_range(0, 7))
         0:       v = 27'd0;
         1:       v = 27'd99999999;
         2:       v = 27'($urandom_range(100000000, 134217727));
         default: v = 27'($urandom_range(0, 99999999));
      endcase
      return v;
   endfunction

   task automatic add_write(input logic [1:0] index, input logic [26:0] value);
      script_row_type row;
      row = '0;
      row.is_write = 1'b1;
      row.reg_index = index;
      row.reg_value = value;
      script.push_back(row);
   endtask

   task automatic add_item(input req_type item);
      script_row_type row;
      row = '0;
      row.item = item;
      script.push_back(row);
   endtask

   task automatic add_checked(input req_type item, input logic [26:0] freq,
                              input logic [31:0] bcd, input logic [35:0] synth,
                              input logic clamp);
      script_row_type row;
      row = '0;
      row.item = item;
      row.typed = 1'b1;
      row.result.tuned_frequency = freq;
      row.result.bcd_digits = bcd;
      row.result.synth_word = synth;
      row.result.was_clamped = clamp;
      script.push_back(row);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [26:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (index)
         CSR_MIN:  freq_min_reg = value;
         CSR_MAX:  freq_max_reg = value;
         CSR_HOME: freq_home_reg = value;
         default: ;
      endcase
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_tunings.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic send_item(input req_type item, input bit typed, input rsp_type result);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      row_typed = typed;
      row_result = result;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 40)) @(negedge clock);
         if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(20, 120);
         else burst_left = $urandom_range(1, 12);
      end
   endtask

   initial begin : receiver
      int style;
      int span;
      int i;
      rsp_ready = 1'b0;
      forever begin
         style = $urandom_range(0, 2);
         span = $urandom_range(1, 96);
         for (i = 0; i < span; i++) begin
            @(negedge clock);
            case (style)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= (i >= span / 2);
            endcase
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type predicted;
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = next_tuning(req_data);
            expected_tunings.push_back(row_typed ? row_result : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_tunings.size() == 0) begin
               $display("%0t unexpected response: expected none, actual %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_tunings.pop_front();
               if (rsp_data.tuned_frequency !== want.tuned_frequency) begin
                  $display("%0t tuned_frequency: expected %0d, actual %0d", $time,
                           want.tuned_frequency, rsp_data.tuned_frequency);
                  mismatch_count++;
               end
               if (rsp_data.bcd_digits !== want.bcd_digits) begin
                  $display("%0t bcd_digits: expected %h, actual %h", $time,
                           want.bcd_digits, rsp_data.bcd_digits);
                  mismatch_count++;
               end
               if (rsp_data.synth_word !== want.synth_word) begin
                  $display("%0t synth_word: expected %0d, actual %0d", $time,
                           want.synth_word, rsp_data.synth_word);
                  mismatch_count++;
               end
               if (rsp_data.was_clamped !== want.was_clamped) begin
                  $display("%0t was_clamped: expected %b, actual %b", $time,
                           want.was_clamped, rsp_data.was_clamped);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin : stimulus
      req_type     item;
      rsp_type     none;
      logic [26:0] lo_pick;
      logic [26:0] hi_pick;
      logic [26:0] swap;
      int          phase;
      int          n;
      int          i;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wen = 1'b0;
      csr_index = CSR_MIN;
      csr_wdata = '0;
      freq_min_reg = 27'd1000000;
      freq_max_reg = 27'd30000000;
      freq_home_reg = 27'd14150000;
      tracked_frequency = 27'd14150000;
      mismatch_count = 0;
      burst_left = 0;
      row_typed = 1'b0;
      row_result = '0;
      none = '0;

      add_checked(make_req(OP_HOME, 8'd0, 3'd0, MODE_USB),
                  27'd14150000, 32'h14150000, 36'd5659400000, 1'b0);
      add_checked(make_req(OP_TUNE, 8'd127, 3'd0, MODE_OTHER),
                  27'd30000000, 32'h30000000, 36'd12000000000, 1'b1);
      add_checked(make_req(OP_TUNE, 8'h80, 3'd0, MODE_LSB),
                  27'd1000000, 32'h01000000, 36'd400600000, 1'b1);
      add_checked(make_req(OP_TUNE, 8'd0, 3'd7, MODE_CW),
                  27'd1000000, 32'h01000000, 36'd399720000, 1'b0);
      add_item(make_req(OP_TUNE, 8'd1, 3'd7, MODE_OTHER));
      add_item(make_req(OP_TUNE, 8'hFF, 3'd7, MODE_USB));
      add_item(make_req(OP_TUNE, 8'hFF, 3'd7, MODE_LSB));
      add_item(make_req(OP_TUNE, 8'd3, 3'd1, MODE_CW));
      add_item(make_req(OP_TUNE, 8'hFE, 3'd2, MODE_OTHER));
      add_item(make_req(OP_TUNE, 8'd5, 3'd3, MODE_USB));
      add_item(make_req(OP_TUNE, 8'hF9, 3'd4, MODE_LSB));
      add_item(make_req(OP_TUNE, 8'd9, 3'd5, MODE_CW));
      add_item(make_req(OP_TUNE, 8'd55, 3'd6, MODE_OTHER));

      add_write(CSR_MIN, 27'd0);
      add_write(CSR_MAX, 27'd99999999);
      add_write(CSR_HOME, 27'd0);
      add_checked(make_req(OP_HOME, 8'h5A, 3'd5, MODE_USB), 27'd0, 32'h0, 36'd0, 1'b0);
      add_item(make_req(OP_TUNE, 8'd0, 3'd7, MODE_LSB));
      add_checked(make_req(OP_TUNE, 8'hFF, 3'd7, MODE_CW), 27'd0, 32'h0, 36'd0, 1'b1);
      add_item(make_req(OP_TUNE, 8'd99, 3'd1, MODE_OTHER));
      add_checked(make_req(OP_TUNE, 8'd127, 3'd2, MODE_OTHER),
                  27'd99999999, 32'h99999999, 36'd39999999600, 1'b1);

      add_write(CSR_MAX, 27'h7FFFFFF);
      add_write(CSR_HOME, 27'h7FFFFFF);
      add_checked(make_req(OP_HOME, 8'hA5, 3'd2, MODE_CW),
                  27'd99999999, 32'h99999999, 36'd39999719600, 1'b0);
      add_checked(make_req(OP_TUNE, 8'd127, 3'd0, MODE_LSB),
                  27'd99999999, 32'h99999999, 36'd40000599600, 1'b1);
      add_item(make_req(OP_TUNE, 8'd0, 3'd7, MODE_USB));

      add_write(CSR_MIN, 27'd50000000);
      add_write(CSR_MAX, 27'd20000000);
      add_write(CSR_HOME, 27'd20000000);
      add_item(make_req(OP_HOME, 8'd0, 3'd7, MODE_OTHER));
      add_item(make_req(OP_TUNE, 8'hFF, 3'd7, MODE_USB));
      add_item(make_req(OP_TUNE, 8'd1, 3'd7, MODE_LSB));
      add_item(make_req(OP_TUNE, 8'd0, 3'd7, MODE_CW));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < script.size(); i++) begin
         if (script[i].is_write) begin
            settle_block();
            write_register(script[i].reg_index, script[i].reg_value);
         end else begin
            send_item(script[i].item, script[i].typed, script[i].result);
         end
      end

      for (phase = 0; phase < 7; phase++) begin
         settle_block();
         lo_pick = pick_frequency();
         hi_pick = pick_frequency();
         if (lo_pick > hi_pick && $urandom_range(0, 3) != 0) begin
            swap = lo_pick;
            lo_pick = hi_pick;
            hi_pick = swap;
         end
         write_register(CSR_MIN, lo_pick);
         write_register(CSR_MAX, hi_pick);
         write_register(CSR_HOME, pick_frequency());
         for (n = 0; n < 200; n++) begin
            item.operation = ($urandom_range(0, 9) == 0) ? OP_HOME : OP_TUNE;
            if ($urandom_range(0, 1) == 1) item.rotations = 8'($urandom_range(0, 6) - 3);
            else item.rotations = 8'($urandom_range(0, 255));
            item.cursor_position = 3'($urandom_range(0, 7));
            item.sideband_mode = 2'($urandom_range(0, 3));
            send_item(item, 1'b0, none);
         end
      end

      settle_block();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
